// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk with rst_n as the reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define NMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising edge, reset included
`define NMV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/nmv_pkg.sv =====
// ----------------------------------------------------------------------------
// nmv_pkg
// sizes, codes and shared types of the neighbor majority vote block
// ----------------------------------------------------------------------------
package nmv_pkg;

    localparam int MAX_ENTITIES = 4096;
    localparam int MAX_LABELS   = 64;
    localparam int MAX_GROUP    = 4096;

    localparam int ENT_W = $clog2(MAX_ENTITIES);
    localparam int LAB_W = $clog2(MAX_LABELS);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int REF_W = 14;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CREDIT_W   = FIFO_CNT_W + 1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REF  = 1'b1;

    // one access per cycle to the label table
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [ENT_W-1:0] addr;
        logic [LAB_W-1:0] wr_data;
    } tbl_req_t;

    // write port of the count memory
    typedef struct packed {
        logic             en;
        logic [LAB_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } cnt_wr_t;

endpackage

// ===== hdl/nmv_label_table.sv =====
// ----------------------------------------------------------------------------
// nmv_label_table
// label per entity, single port, registered read
// ----------------------------------------------------------------------------
module nmv_label_table
    import nmv_pkg::*;
(
    input  logic             clk,
    input  tbl_req_t         req,
    output logic [LAB_W-1:0] rd_data
);

    logic [LAB_W-1:0] mem [MAX_ENTITIES];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

// ===== hdl/nmv_count_ram.sv =====
// ----------------------------------------------------------------------------
// nmv_count_ram
// per-label counts of the open group, one write and one registered read
// ----------------------------------------------------------------------------
module nmv_count_ram
    import nmv_pkg::*;
(
    input  logic             clk,
    input  cnt_wr_t          wr,
    input  logic [LAB_W-1:0] rd_addr,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] mem [MAX_LABELS];

    // read returns the old value when it hits the entry being written
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/nmv_out_fifo.sv =====
// ----------------------------------------------------------------------------
// nmv_out_fifo
// small queue of finished words in front of the output channel
// ----------------------------------------------------------------------------
module nmv_out_fifo
    import nmv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [LAB_W-1:0]      push_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LAB_W-1:0]      winner_label,
    output logic [FIFO_CNT_W-1:0] fill
);

    logic [LAB_W-1:0]      buf_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign out_valid    = (cnt_reg != '0);
    assign winner_label = buf_mem[rd_ptr_reg];
    assign fill         = cnt_reg;
    assign pop          = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/neighbor_majority_vote_top.sv =====
// ----------------------------------------------------------------------------
// neighbor_majority_vote_top
// most frequent part label over a group of neighbor references
// ----------------------------------------------------------------------------
// Takes one word per clock, table loads and references alike. A reference
// goes through three stages: label table read, count memory read, then
// count update with the running best; the group result, carried by the
// s1 and s2 close registers, leaves the update stage and waits in a
// four-word output queue. Input is held off only while that queue plus the
// closing references still in flight would fill it, so with the output
// taken each cycle the rate is one word per cycle. Back-to-back hits on the
// same label are forwarded around the count memory. Label table entries
// read as garbage until loaded. Counts clear at once when a group closes.
module neighbor_majority_vote_top
    import nmv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  logic [ENT_W-1:0]        entity_index,
    input  logic [LAB_W-1:0]        label_value,
    input  logic signed [REF_W-1:0] neighbor_ref,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LAB_W-1:0]        winner_label
);

    logic                  accept;
    logic                  is_ref;
    logic [REF_W-1:0]      mag;
    logic                  ref_ok;
    logic [ENT_W-1:0]      ref_addr;
    tbl_req_t              tbl_req;
    logic [LAB_W-1:0]      tbl_rd_data;

    // stage 1: label read in flight
    logic                  s1_cnt_reg, s1_close_reg;
    // stage 2: count read in flight, update this cycle
    logic                  s2_cnt_reg, s2_close_reg;
    logic [LAB_W-1:0]      s2_label_reg;

    logic [CNT_W-1:0]      cnt_rd_data;
    cnt_wr_t               cnt_wr;

    logic                  fwd_valid_reg;
    logic [LAB_W-1:0]      fwd_label_reg;
    logic [CNT_W-1:0]      fwd_count_reg;

    logic [MAX_LABELS-1:0] touched_reg, touched_next;
    logic [LAB_W-1:0]      best_label_reg, best_label_next;
    logic [CNT_W-1:0]      best_count_reg, best_count_next;

    logic [CNT_W-1:0]      cur_count;
    logic [CNT_W-1:0]      new_count;
    logic                  take_new;
    logic [LAB_W-1:0]      result_label;
    logic [FIFO_CNT_W-1:0] fifo_fill;
    logic [CREDIT_W-1:0]   credit_used;

    // ---- stage 0: decode and table access
    assign accept = in_valid && in_ready;
    assign is_ref = (kind == KIND_REF);

    always_comb
    begin
        mag      = neighbor_ref[REF_W-1] ? (~neighbor_ref + 1'b1) : neighbor_ref;
        ref_ok   = (mag != '0) && (mag <= REF_W'(MAX_ENTITIES));
        ref_addr = ENT_W'(mag - 1'b1);

        tbl_req.wr_en   = accept && !is_ref;
        tbl_req.rd_en   = accept && is_ref && ref_ok;
        tbl_req.addr    = is_ref ? ref_addr : entity_index;
        tbl_req.wr_data = label_value;
    end

    nmv_label_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    nmv_count_ram u_counts (
        .clk     (clk),
        .wr      (cnt_wr),
        .rd_addr (tbl_rd_data),
        .rd_data (cnt_rd_data)
    );

    // ---- stage 2: count update and running best
    always_comb
    begin
        if (!touched_reg[s2_label_reg])
        begin
            cur_count = '0;
        end
        else if (fwd_valid_reg && (fwd_label_reg == s2_label_reg))
        begin
            cur_count = fwd_count_reg;
        end
        else
        begin
            cur_count = cnt_rd_data;
        end

        new_count = (cur_count < CNT_W'(MAX_GROUP)) ? cur_count + 1'b1 : cur_count;
        take_new  = (new_count > best_count_reg) ||
                    ((new_count == best_count_reg) && (s2_label_reg < best_label_reg));

        cnt_wr.en   = s2_cnt_reg;
        cnt_wr.addr = s2_label_reg;
        cnt_wr.data = new_count;

        result_label    = best_label_reg;
        best_label_next = best_label_reg;
        best_count_next = best_count_reg;
        touched_next    = touched_reg;
        if (s2_cnt_reg)
        begin
            touched_next = touched_reg | (MAX_LABELS'(1) << s2_label_reg);
            if (take_new)
            begin
                result_label    = s2_label_reg;
                best_label_next = s2_label_reg;
                best_count_next = new_count;
            end
        end
        if (s2_close_reg)
        begin
            touched_next    = '0;
            best_label_next = '0;
            best_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cnt_reg     <= 1'b0;
            s1_close_reg   <= 1'b0;
            s2_cnt_reg     <= 1'b0;
            s2_close_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            touched_reg    <= '0;
            best_label_reg <= '0;
            best_count_reg <= '0;
        end
        else
        begin
            s1_cnt_reg     <= tbl_req.rd_en;
            s1_close_reg   <= accept && is_ref && last;
            s2_cnt_reg     <= s1_cnt_reg;
            s2_close_reg   <= s1_close_reg;
            fwd_valid_reg  <= cnt_wr.en;
            touched_reg    <= touched_next;
            best_label_reg <= best_label_next;
            best_count_reg <= best_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_label_reg  <= tbl_rd_data;
        fwd_label_reg <= cnt_wr.addr;
        fwd_count_reg <= cnt_wr.data;
    end

    // ---- output queue and input credit
    nmv_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s2_close_reg),
        .push_data    (result_label),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .winner_label (winner_label),
        .fill         (fifo_fill)
    );

    // closing references in flight already own a queue slot
    assign credit_used = CREDIT_W'(fifo_fill) + CREDIT_W'(s1_close_reg) +
                         CREDIT_W'(s2_close_reg);
    assign in_ready    = (credit_used < CREDIT_W'(FIFO_DEPTH));

endmodule

// ===== hdl/nmv_checker.sv =====
// ----------------------------------------------------------------------------
// nmv_checker
// port-level checks of the neighbor majority vote block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmv_checker
    import nmv_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    kind,
    input logic                    last,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [LAB_W-1:0]        winner_label
);

    // a stalled word stays
    `NMV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped while stalled")

    // and its label does not change
    `NMV_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(winner_label), "output word changed while stalled")

    // a result from an empty queue rises after its closing reference passes both close registers and the queue
    `NMV_ASSERT(a_out_origin, $rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_REF) && last, 3), "result without a closing reference")

    // input is only held off while results are waiting
    `NMV_ASSERT(a_ready_backpressure, !in_ready |-> out_valid, "input stalled with no result pending")

endmodule

bind neighbor_majority_vote_top nmv_checker u_nmv_checker (.*);

// ===== tb/neighbor_majority_vote_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_majority_vote_top_test
// self-checking testbench of the neighbor majority vote block
// ----------------------------------------------------------------------------
// Loads part labels into the label table and sends groups of signed neighbor
// references with random idle gaps on both sides. A predictor written
// against the block's behavior keeps its own copy of the table and the
// per-group tally and queues the winning label of every closed group. Each
// result taken from the block is checked against the oldest queued label.
// Covers null and far references, ties, table reloads inside a group
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module neighbor_majority_vote_top_test;
    import nmv_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_WORDS   = 1800;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REF_SPAN       = 8192;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    kind;
    logic [ENT_W-1:0]        entity_index;
    logic [LAB_W-1:0]        label_value;
    logic signed [REF_W-1:0] neighbor_ref;
    logic                    last;
    logic                    out_valid;
    logic                    out_ready;
    logic [LAB_W-1:0]        winner_label;

    neighbor_majority_vote_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .entity_index (entity_index),
        .label_value  (label_value),
        .neighbor_ref (neighbor_ref),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .winner_label (winner_label)
    );

    // predictor state
    logic [LAB_W-1:0] label_mem [MAX_ENTITIES];
    bit               entry_loaded [MAX_ENTITIES];
    int unsigned      loaded_ids [$];
    int unsigned      label_hits [MAX_LABELS];
    logic [LAB_W-1:0] lead_label;
    int unsigned      lead_count;
    logic [LAB_W-1:0] expected_winners [$];

    int   mismatches = 0;
    int   cycle_count = 0;
    int   tx_gap_max;
    int   rx_gap_max;
    logic rx_hold;
    event rx_hold_go;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic clear_tally();
        foreach (label_hits[i])
            label_hits[i] = 0;
        lead_label = '0;
        lead_count = 0;
    endtask

    // applies one accepted word to the predictor
    task automatic tally_word(input logic k, input logic [ENT_W-1:0] ent,
                              input logic [LAB_W-1:0] lab,
                              input logic signed [REF_W-1:0] nref, input logic lst);
        int               mag;
        int unsigned      cnt;
        logic [LAB_W-1:0] hit;
        if (k == KIND_LOAD)
        begin
            // index and label widths keep both in range, last is ignored
            label_mem[ent] = lab;
            if (!entry_loaded[ent])
            begin
                entry_loaded[ent] = 1'b1;
                loaded_ids.push_back(ent);
            end
            return;
        end
        mag = (nref < 0) ? -int'(nref) : int'(nref);
        if (mag != 0 && mag <= MAX_ENTITIES)
        begin
            hit = label_mem[mag - 1];
            cnt = label_hits[hit];
            if (cnt < MAX_GROUP)
                cnt++;
            label_hits[hit] = cnt;
            if (cnt > lead_count || (cnt == lead_count && hit < lead_label))
            begin
                lead_count = cnt;
                lead_label = hit;
            end
        end
        if (lst)
        begin
            expected_winners.push_back(lead_label);
            clear_tally();
        end
    endtask

    // offers one word after a random gap and waits until it is taken
    task automatic send_word(input logic k, input logic [ENT_W-1:0] ent,
                             input logic [LAB_W-1:0] lab,
                             input logic signed [REF_W-1:0] nref, input logic lst);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        entity_index <= ent;
        label_value  <= lab;
        neighbor_ref <= nref;
        last         <= lst;
        do @(posedge clk); while (!in_ready);
        tally_word(k, ent, lab, nref, lst);
    endtask

    task automatic send_load(input int ent, input int lab);
        send_word(KIND_LOAD, ENT_W'(ent), LAB_W'(lab), REF_W'($urandom), 1'($urandom));
    endtask

    task automatic send_ref(input int nref, input logic lst);
        send_word(KIND_REF, ENT_W'($urandom), LAB_W'($urandom), REF_W'(nref), lst);
    endtask

    // mostly loaded entries, now and then a null or an out-of-table reference
    function automatic int random_ref();
        int pick;
        int mag;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick == 1)
            mag = $urandom_range(MAX_ENTITIES + 1, REF_SPAN);
        else
            mag = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)] + 1;
        if (mag == REF_SPAN || $urandom_range(0, 1) == 1)
            return -mag;
        return mag;
    endfunction

    function automatic int random_label();
        if ($urandom_range(0, 1) == 1)
            return $urandom_range(0, 3);
        return $urandom_range(0, MAX_LABELS - 1);
    endfunction

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_winners.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed();
        send_load(0, 0);
        send_load(MAX_ENTITIES - 1, MAX_LABELS - 1);
        send_load(1, MAX_LABELS - 1);
        send_load(2, 5);
        // last on a load closes nothing
        send_word(KIND_LOAD, ENT_W'(3), LAB_W'(2), REF_W'(-1), 1'b1);
        send_ref(1, 1'b0);
        send_ref(-MAX_ENTITIES, 1'b0);
        send_ref(MAX_ENTITIES, 1'b0);
        send_ref(0, 1'b0);
        send_ref(-REF_SPAN, 1'b0);
        send_ref(MAX_ENTITIES + 1, 1'b0);
        send_ref(REF_SPAN - 1, 1'b0);
        send_ref(2, 1'b1);
        // groups with nothing counted
        send_ref(0, 1'b1);
        send_ref(-(MAX_ENTITIES + 1), 1'b1);
        // ties go to the smaller label, here sent after the larger one
        send_ref(3, 1'b0);
        send_ref(1, 1'b1);
        send_ref(-2, 1'b0);
        send_ref(3, 1'b1);
        // reload an entry, then read it back
        send_load(0, 7);
        send_ref(-1, 1'b1);
        drain_results();
    endtask

    task automatic test_random_groups();
        int sent;
        int glen;
        sent = 0;
        repeat (150)
        begin
            send_load($urandom_range(0, MAX_ENTITIES - 1), random_label());
            sent++;
        end
        while (sent < RANDOM_WORDS)
        begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
            glen = $urandom_range(1, 12);
            for (int i = 0; i < glen; i++)
            begin
                // table writes landing inside an open group
                if ($urandom_range(0, 7) == 0)
                begin
                    send_load($urandom_range(0, MAX_ENTITIES - 1), random_label());
                    sent++;
                end
                send_ref(random_ref(), i == glen - 1);
                sent++;
            end
        end
        drain_results();
        tx_gap_max = 18;
        rx_gap_max = 18;
    endtask

    // receiver holds off while the sender keeps the input busy
    task automatic test_backpressure();
        tx_gap_max = 0;
        rx_gap_max = 0;
        -> rx_hold_go;
        repeat (40)
            send_ref(random_ref(), 1'($urandom));
        send_ref(random_ref(), 1'b1);
        drain_results();
        tx_gap_max = 18;
        rx_gap_max = 18;
    endtask

    // hold-off counted here, apart from the receiver
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(rx_hold_go);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_n = $urandom_range(0, rx_gap_max);
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            while (rx_hold)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : check_winner
        logic [LAB_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_winners.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual winner_label %0d",
                         $time, winner_label);
                mismatches++;
            end
            else
            begin
                want = expected_winners.pop_front();
                if (winner_label !== want)
                begin
                    $display("%0t: winner_label mismatch, expected %0d, actual %0d",
                             $time, want, winner_label);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_LOAD;
        entity_index = '0;
        label_value  = '0;
        neighbor_ref = '0;
        last         = 1'b0;
        tx_gap_max   = 18;
        rx_gap_max   = 18;
        clear_tally();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_groups();
        test_backpressure();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
